// ----- sv/dfp_pkg.sv -----
// Shared types, operation codes and power-of-ten table for the decimal
// fixed-point ALU. No dependencies.
`default_nettype none
package dfp_pkg;

  localparam int MAX_DECIMAL_SCALE = 8;
  localparam int DIV_STAGES        = 64;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_GT  = 4'd4;
  localparam logic [3:0] OP_LT  = 4'd5;
  localparam logic [3:0] OP_EQ  = 4'd6;
  localparam logic [3:0] OP_NE  = 4'd7;
  localparam logic [3:0] OP_LE  = 4'd8;
  localparam logic [3:0] OP_GE  = 4'd9;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  localparam logic [63:0] POW10 [0:16] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
    64'd100000000000, 64'd1000000000000, 64'd10000000000000,
    64'd100000000000000, 64'd1000000000000000, 64'd10000000000000000
  };

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [63:0] a_value;
    logic [3:0]         a_scale;
    logic signed [63:0] b_value;
    logic [3:0]         b_scale;
  } in_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [3:0]         result_scale;
    logic               compare_true;
    logic               fault;
  } out_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic [26:0] pa;
    logic [26:0] pb;
    logic [63:0] xw;
    logic [63:0] yw;
    logic [63:0] dv;
    logic        neg;
    logic        zero;
    logic [3:0]  hi_s;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/dfp_front.sv -----
// Front end: clamps scales, picks alignment factors and divider operands.
// Depends on dfp_pkg.
`default_nettype none
module dfp_front (
  input  dfp_pkg::in_t  in_data,
  output dfp_pkg::job_t job
);
  import dfp_pkg::*;

  logic [3:0]  as_c, bs_c, hi_s, lo_s;
  logic [4:0]  kdiv;
  logic [63:0] mag_a, mag_b;

  always_comb begin
    as_c = (in_data.a_scale > 4'(MAX_DECIMAL_SCALE)) ? 4'(MAX_DECIMAL_SCALE) : in_data.a_scale;
    bs_c = (in_data.b_scale > 4'(MAX_DECIMAL_SCALE)) ? 4'(MAX_DECIMAL_SCALE) : in_data.b_scale;
    hi_s = (as_c > bs_c) ? as_c : bs_c;
    lo_s = (as_c > bs_c) ? bs_c : as_c;
    kdiv = 5'(bs_c) + 5'(hi_s) - 5'(as_c);
    mag_a = in_data.a_value[63] ? (64'd0 - in_data.a_value) : in_data.a_value;
    mag_b = in_data.b_value[63] ? (64'd0 - in_data.b_value) : in_data.b_value;

    job.op   = in_data.operation;
    job.a    = in_data.a_value;
    job.b    = in_data.b_value;
    job.pa   = POW10[5'(hi_s - as_c)][26:0];
    job.pb   = POW10[5'(hi_s - bs_c)][26:0];
    job.xw   = mag_a;
    job.neg  = in_data.a_value[63] ^ in_data.b_value[63];
    job.hi_s = hi_s;
    if (in_data.operation == OP_DIV) begin
      job.yw   = POW10[kdiv];
      job.dv   = mag_b;
      job.zero = (in_data.a_value == 64'sd0) || (in_data.b_value == 64'sd0);
    end else begin
      job.yw   = mag_b;
      job.dv   = POW10[5'(lo_s)];
      job.zero = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dfp_queue.sv -----
// Two-entry word queue between front and back ends.
// Depends on dfp_pkg.
`default_nettype none
module dfp_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  dfp_pkg::job_t  push_data,
  output logic           full,
  input  wire            pop,
  output logic           head_valid,
  output dfp_pkg::job_t  head_data
);
  import dfp_pkg::*;

  job_t       mem_r [0:1];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

// ----- sv/dfp_back.sv -----
// Back end: alignment and wide multiply, add/compare, 64-stage divider
// pipeline and output register. Depends on dfp_pkg.
`default_nettype none
module dfp_back (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           job_valid,
  input  dfp_pkg::job_t job,
  output logic          job_take,
  output logic          out_valid,
  input  wire           out_ready,
  output dfp_pkg::out_t out_data
);
  import dfp_pkg::*;

  typedef struct packed {
    logic [3:0]  op;
    logic        neg;
    logic        zero;
    logic [3:0]  hi_s;
    logic [63:0] dv;
    logic [58:0] apl, aph, bpl, bph;
    logic [63:0] mll, mlh, mhl, mhh;
  } s1_t;

  typedef struct packed {
    logic [3:0]   op;
    logic         neg;
    logic         zero;
    logic [3:0]   hi_s;
    logic [63:0]  dv;
    logic [63:0]  an, bn;
    logic [127:0] p;
  } s2_t;

  typedef struct packed {
    logic        is_div;
    logic        ovf;
    logic        neg;
    logic [63:0] dv;
    logic [63:0] rem;
    logic [63:0] q;
    out_t        res;
  } dst_t;

  function automatic dst_t div_step(dst_t d);
    logic [64:0] t;
    logic        ge;
    dst_t        n;
    t = {d.rem, d.q[63]};
    ge = t >= {1'b0, d.dv};
    n = d;
    n.rem = ge ? 64'(t - {1'b0, d.dv}) : t[63:0];
    n.q = {d.q[62:0], ge};
    return n;
  endfunction

  logic                  en;
  s1_t                   s1_r;
  s2_t                   s2_r;
  logic                  v1_r, v2_r, vo_r;
  logic [DIV_STAGES-1:0] vd_r;
  dst_t                  dst_r [0:DIV_STAGES-1];
  dst_t                  s3;
  out_t                  out_r, fin;
  logic [63:0]           sum, dif;
  logic                  lt_ab, lt_ba;

  assign en        = !vo_r || out_ready;
  assign job_take  = en && job_valid;
  assign out_valid = vo_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vd_r <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= job_valid;
      v2_r <= v1_r;
      vd_r <= {vd_r[DIV_STAGES-2:0], v2_r};
      vo_r <= vd_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.op   <= job.op;
      s1_r.neg  <= job.neg;
      s1_r.zero <= job.zero;
      s1_r.hi_s <= job.hi_s;
      s1_r.dv   <= job.dv;
      s1_r.apl  <= job.a[31:0] * job.pa;
      s1_r.aph  <= job.a[63:32] * job.pa;
      s1_r.bpl  <= job.b[31:0] * job.pb;
      s1_r.bph  <= job.b[63:32] * job.pb;
      s1_r.mll  <= job.xw[31:0] * job.yw[31:0];
      s1_r.mlh  <= job.xw[31:0] * job.yw[63:32];
      s1_r.mhl  <= job.xw[63:32] * job.yw[31:0];
      s1_r.mhh  <= job.xw[63:32] * job.yw[63:32];

      s2_r.op   <= s1_r.op;
      s2_r.neg  <= s1_r.neg;
      s2_r.zero <= s1_r.zero;
      s2_r.hi_s <= s1_r.hi_s;
      s2_r.dv   <= s1_r.dv;
      s2_r.an   <= 64'(s1_r.apl) + {s1_r.aph[31:0], 32'd0};
      s2_r.bn   <= 64'(s1_r.bpl) + {s1_r.bph[31:0], 32'd0};
      s2_r.p    <= 128'(s1_r.mll) + {32'd0, s1_r.mlh, 32'd0}
                 + {32'd0, s1_r.mhl, 32'd0} + {s1_r.mhh, 64'd0};

      dst_r[0] <= div_step(s3);
      for (int i = 1; i < DIV_STAGES; i++) begin
        dst_r[i] <= div_step(dst_r[i-1]);
      end
      out_r <= fin;
    end
  end

  always_comb begin
    sum   = s2_r.an + s2_r.bn;
    dif   = s2_r.an - s2_r.bn;
    lt_ab = (s2_r.an ^ SIGN64) < (s2_r.bn ^ SIGN64);
    lt_ba = (s2_r.bn ^ SIGN64) < (s2_r.an ^ SIGN64);
    s3.is_div = (s2_r.op == OP_MUL) || (s2_r.op == OP_DIV);
    s3.ovf    = s2_r.zero || (s2_r.p[127:64] >= s2_r.dv);
    s3.neg    = s2_r.neg;
    s3.dv     = s2_r.dv;
    s3.rem    = s2_r.p[127:64];
    s3.q      = s2_r.p[63:0];
    s3.res    = '0;
    unique case (s2_r.op)
      OP_ADD: begin
        if (!(s2_r.an[63] == s2_r.bn[63] && sum[63] != s2_r.an[63])) begin
          s3.res.result_value = sum;
          s3.res.result_scale = s2_r.hi_s;
        end else begin
          s3.res.fault = 1'b1;
        end
      end
      OP_SUB: begin
        if (!(s2_r.an[63] != s2_r.bn[63] && dif[63] != s2_r.an[63])) begin
          s3.res.result_value = dif;
          s3.res.result_scale = s2_r.hi_s;
        end else begin
          s3.res.fault = 1'b1;
        end
      end
      OP_MUL, OP_DIV: s3.res.result_scale = s2_r.hi_s;
      OP_GT: s3.res.compare_true = lt_ba;
      OP_LT: s3.res.compare_true = lt_ab;
      OP_EQ: s3.res.compare_true = (s2_r.an == s2_r.bn);
      OP_NE: s3.res.compare_true = (s2_r.an != s2_r.bn);
      OP_LE: s3.res.compare_true = !lt_ba;
      OP_GE: s3.res.compare_true = !lt_ab;
      default: s3.res = '0;
    endcase
  end

  always_comb begin
    dst_t d;
    d   = dst_r[DIV_STAGES-1];
    fin = d.res;
    if (d.is_div) begin
      if (d.ovf || (d.neg ? (d.q > SIGN64) : (d.q >= SIGN64))) begin
        fin = '0;
        fin.fault = 1'b1;
      end else begin
        fin.result_value = d.neg ? (64'd0 - d.q) : d.q;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/decimal_fixed_point_alu.sv -----
// Top level of the decimal fixed-point ALU: front end, word queue, back end.
// Depends on dfp_pkg, dfp_front, dfp_queue, dfp_back.
//
// Usage:
//   in_valid/in_ready/in_data carry one word: operation code and two
//   decimal fixed-point operands. out_valid/out_ready/out_data return one
//   result word per input word, in order.
//   Path: the accepting edge writes the queue, then two multiply stages,
//   64 divider stages with the add/compare logic ahead of the first, and
//   the output register. Every operation runs the same pipeline, so order
//   is kept. Throughput: one word per cycle while the output is not
//   stalled, set by the fully pipelined 64-stage restoring divider and
//   split 32x32 multipliers.
//   Reset (rst_n low, synchronous) empties the queue and the pipeline.
//   While out_valid is high and out_ready low the back end holds all stages;
//   the two-entry queue absorbs up to two more words, then in_ready drops.
`default_nettype none
module decimal_fixed_point_alu (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  dfp_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output dfp_pkg::out_t  out_data
);
  import dfp_pkg::*;

  job_t job_in, job_head;
  logic q_full, q_valid, q_pop;

  assign in_ready = !q_full;

  dfp_front u_front (
    .in_data (in_data),
    .job     (job_in)
  );

  dfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !q_full),
    .push_data  (job_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (job_head)
  );

  dfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (job_head),
    .job_take  (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for decimal_fixed_point_alu: drives operation words, predicts each
// result with an independent scaled-decimal model and checks results in order.
// Depends on dfp_pkg and the decimal_fixed_point_alu RTL.
`timescale 1ns / 100ps
module tb;
  import dfp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int send_idle = 0;
  int recv_idle = 0;
  int n_errors = 0;
  out_t expected_results [$];

  decimal_fixed_point_alu i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] ten_to(int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic out_t alu_result(in_t w);
    out_t r;
    int sa, sb, shi, slo;
    logic [63:0] an, bn, s;
    logic [127:0] mag;
    logic neg, ok, cmp;
    r = '0;
    sa = (w.a_scale > MAX_DECIMAL_SCALE) ? MAX_DECIMAL_SCALE : w.a_scale;
    sb = (w.b_scale > MAX_DECIMAL_SCALE) ? MAX_DECIMAL_SCALE : w.b_scale;
    shi = (sa > sb) ? sa : sb;
    slo = (sa > sb) ? sb : sa;
    an = w.a_value * ten_to(shi - sa);
    bn = w.b_value * ten_to(shi - sb);
    neg = w.a_value[63] ^ w.b_value[63];
    ok = 1'b1;
    cmp = 1'b0;
    s = '0;
    mag = '0;
    case (w.operation)
      OP_ADD: begin
        s = an + bn;
        ok = !(an[63] == bn[63] && s[63] != an[63]);
      end
      OP_SUB: begin
        s = an - bn;
        ok = !(an[63] != bn[63] && s[63] != an[63]);
      end
      OP_MUL, OP_DIV: begin
        if (w.operation == OP_MUL) begin
          mag = ({64'd0, abs64(w.a_value)} * {64'd0, abs64(w.b_value)})
                / {64'd0, ten_to(slo)};
        end else if (w.a_value == 0 || w.b_value == 0) begin
          ok = 1'b0;
        end else begin
          mag = ({64'd0, abs64(w.a_value)} * {64'd0, ten_to(sb + shi - sa)})
                / {64'd0, abs64(w.b_value)};
        end
        if (ok) begin
          if (mag[127:64] != 0) ok = 1'b0;
          else if (neg ? (mag[63:0] > SIGN64) : (mag[63:0] >= SIGN64)) ok = 1'b0;
          else s = neg ? -mag[63:0] : mag[63:0];
        end
      end
      OP_GT: cmp = $signed(an) > $signed(bn);
      OP_LT: cmp = $signed(an) < $signed(bn);
      OP_EQ: cmp = an == bn;
      OP_NE: cmp = an != bn;
      OP_LE: cmp = $signed(an) <= $signed(bn);
      OP_GE: cmp = $signed(an) >= $signed(bn);
      default: ;
    endcase
    if (w.operation <= OP_DIV) begin
      if (ok) begin
        r.result_value = s;
        r.result_scale = shi[3:0];
      end else begin
        r.fault = 1'b1;
      end
    end
    r.compare_true = cmp;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", out_data.result_value, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_value != want.result_value)
            report_mismatch("result_value", out_data.result_value, want.result_value);
          if (out_data.result_scale != want.result_scale)
            report_mismatch("result_scale", 64'(out_data.result_scale),
                            64'(want.result_scale));
          if (out_data.compare_true != want.compare_true)
            report_mismatch("compare_true", 64'(out_data.compare_true),
                            64'(want.compare_true));
          if (out_data.fault != want.fault)
            report_mismatch("fault", 64'(out_data.fault), 64'(want.fault));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(in_t w);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(alu_result(w));
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = $signed(v) >>> $urandom_range(63);
      1: v = $signed({32'd0, $urandom}) >>> $urandom_range(31);
      2: v = $signed(v[15:0]);
      3: v = {$urandom_range(1) ? SIGN64 : 64'd0} ^ {64{$urandom_range(1) == 1}};
      4: v = $urandom_range(3) - 1;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_op(logic [3:0] op, logic [63:0] a, int sa, logic [63:0] b, int sb);
    in_t w;
    w.operation = op;
    w.a_value = a;
    w.a_scale = sa[3:0];
    w.b_value = b;
    w.b_scale = sb[3:0];
    send_word(w);
  endtask

  task automatic test_directed();
    logic [63:0] mx, mn;
    mx = ~SIGN64;
    mn = SIGN64;
    for (int op = 0; op < 16; op++) send_op(op[3:0], 64'd12345, 2, -64'd678, 5);
    send_op(OP_ADD, mx, 0, 64'd1, 0);
    send_op(OP_SUB, mn, 0, 64'd1, 0);
    send_op(OP_MUL, mn, 0, -64'd1, 0);
    send_op(OP_MUL, mx, 8, mx, 8);
    send_op(OP_DIV, 64'd0, 3, 64'd5, 1);
    send_op(OP_DIV, 64'd5, 1, 64'd0, 3);
    send_op(OP_DIV, mn, 15, -64'd1, 15);
    send_op(OP_EQ, 64'd10, 9, 64'd1, 15);
    send_op(OP_ADD, mx, 0, 64'd1, 15);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_op(4'($urandom_range(99) < 95 ? $urandom_range(9) : $urandom_range(15)),
              rand_value(), $urandom_range(99) < 90 ? $urandom_range(8) : $urandom_range(15),
              rand_value(), $urandom_range(99) < 90 ? $urandom_range(8) : $urandom_range(15));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle = 20;
    recv_idle = 68;
    test_random(410);
    send_idle = 68;
    recv_idle = 20;
    test_random(410);
    send_idle = 0;
    recv_idle = 0;
    test_random(410);
    wait_drained();
    if (n_errors == 0) $display("PASS decimal_fixed_point_alu");
    else $display("FAIL decimal_fixed_point_alu");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL decimal_fixed_point_alu");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/dfp_pkg.sv
sv/dfp_front.sv
sv/dfp_queue.sv
sv/dfp_back.sv
sv/decimal_fixed_point_alu.sv
tb/sv/tb.sv
